>>> rtl/stg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the sine tone generator.
// Used by sine_tone_generator; depends on nothing else.
`timescale 1ns / 1ps

package stg_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int TABLE_BITS   = 10;
    localparam int PHASE_BITS   = 32;

    localparam int IDX_BITS    = TABLE_BITS + 2;
    localparam int QTAB_DEPTH  = (1 << TABLE_BITS) + 1;
    localparam int QTAB_AW     = TABLE_BITS + 1;
    localparam int CNT_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHANS_W     = 5;

    localparam int STEP_W      = 31;
    localparam int AMP_W       = 15;
    localparam int CCOUNT_W    = 4;
    localparam int SAMPLE_W    = 16;
    localparam int Q_W         = 15;
    localparam int PROD_W      = Q_W + AMP_W;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Phase memory: one entry holds the accumulator.
    localparam int PHASE_DEPTH = 2;
    localparam logic [0:0] PHASE_ADDR = 1'b0;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [STEP_W-1:0]   PHASE_STEP_RST    = 31'd42852281;
    localparam logic [AMP_W-1:0]    AMPLITUDE_RST     = 15'd25000;
    localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;

    typedef struct packed {
        logic first_frame;
        logic last_frame;
    } stg_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [2:0]                 channel;
        logic                       frame_end;
        logic                       buffer_end;
    } stg_rsp_t;

    typedef logic [Q_W-1:0] qtab_t [0:QTAB_DEPTH-1];

    // Unsigned long division by shift and subtract; only used while the table is built.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave table of 15-bit magnitudes: Taylor series of sin in Q30 up to x^15,
    // scaled to 32767 with rounding and clipped at full scale.
    function automatic qtab_t build_qtab();
        qtab_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        longint unsigned dv;
        for (int j = 0; j < QTAB_DEPTH; j++)
        begin
            x  = (longint'(j) * HALF_PI_Q30) >> TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = x;
            s  = x;
            for (int n = 1; n <= 7; n++)
            begin
                dv = longint'((2 * n) * (2 * n + 1));
                t  = div_u64((t * x2) >> 30, dv);
                if ((n & 1) == 1)
                begin
                    s = (s >= t) ? (s - t) : 64'd0;
                end
                else
                begin
                    s = s + t;
                end
            end
            q = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (q > 64'd32767)
            begin
                q = 64'd32767;
            end
            tab[j] = q[Q_W-1:0];
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

endpackage

>>> rtl/stg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by sine_tone_generator for the phase accumulator.
`timescale 1ns / 1ps

module stg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sine_tone_generator.sv
// Sine tone generator top level: direct digital synthesis oscillator, one frame per item.
// Depends on stg_pkg (types, constants, sine table) and stg_ram (phase memory).
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload    | Direction
// ---------+---------------------+------------+----------
// req      | req_valid/req_stall | stg_req_t  | in
// rsp      | rsp_valid/rsp_stall | stg_rsp_t  | out
// cfg      | cfg_we              | cfg_index, cfg_data | in
//
// The first result of an item is presented once the item has passed stage 1 (phase),
// stage 2 (table read) and stage 3 (amplitude product) into the output stage.
// Results leave at one per cycle while rsp is not stalled; an item yields as many results as its
// effective channel count (zero counts as one, counts above MAX_CHANNELS as MAX_CHANNELS):
// the output stage sends the frame's sample once per channel.
// The phase lives in one entry of a RAM, read when an item is accepted and written back
// one stage later; a back-to-back item takes the written value through a bypass.
// Reset clears all control state and a valid bit that makes the phase read as zero.
// A stall on rsp holds the output stage and backs up the pipeline to req_stall.

module sine_tone_generator
    import stg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  stg_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output stg_rsp_t             rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [STEP_W-1:0]   phase_step_reg;
    logic [AMP_W-1:0]    amplitude_reg;
    logic [CCOUNT_W-1:0] channel_count_reg;

    // Stage 1: phase read back from RAM, updated and written.
    logic                  s1_valid_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic                  fwd_hit_reg;
    logic [PHASE_BITS-1:0] fwd_phase_reg;
    logic                  phase_valid_reg;

    // Stage 2: registered sine table read.
    logic                  s2_valid_reg;
    logic [Q_W-1:0]        q_reg;
    logic                  s2_neg_reg;
    logic                  s2_last_reg;

    // Stage 3: amplitude product.
    logic                  s3_valid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  s3_neg_reg;
    logic                  s3_last_reg;

    // Stage 4: output, one result per channel.
    logic                  s4_valid_reg;
    logic [SAMPLE_W-1:0]   smp_reg;
    logic                  s4_last_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic                  req_acc;
    logic                  rsp_acc;
    logic                  s1_adv;
    logic                  s2_free;
    logic                  s3_free;
    logic                  s4_free;
    logic                  ch_last;
    logic [CHANS_W-1:0]    cc_ext;
    logic [CHANS_W-1:0]    chans;
    logic [PHASE_BITS-1:0] ram_rd_data;
    logic [PHASE_BITS-1:0] phase_old;
    logic [PHASE_BITS-1:0] phase_next;
    logic [IDX_BITS-1:0]   idx;
    logic [1:0]            quad;
    logic [QTAB_AW-1:0]    k_ext;
    logic [QTAB_AW-1:0]    tab_addr;
    logic [AMP_W-1:0]      mag;
    logic [SAMPLE_W-1:0]   smp_next;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= PHASE_STEP_RST;
            amplitude_reg     <= AMPLITUDE_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data;
                REG_AMPLITUDE:     amplitude_reg     <= cfg_data[AMP_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CCOUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective channel count: zero acts as one, large values saturate.
    assign cc_ext = CHANS_W'(channel_count_reg);
    always_comb
    begin
        priority if (cc_ext == '0)
        begin
            chans = CHANS_W'(1);
        end
        else if (cc_ext > CHANS_W'(MAX_CHANNELS))
        begin
            chans = CHANS_W'(MAX_CHANNELS);
        end
        else
        begin
            chans = cc_ext;
        end
    end

    // Pipeline flow. Each stage moves when the one after it is free.
    assign ch_last   = (CHANS_W'(cnt_reg) + CHANS_W'(1)) == chans;
    assign rsp_acc   = rsp_valid && !rsp_stall;
    assign s4_free   = !s4_valid_reg || (rsp_acc && ch_last);
    assign s3_free   = !s3_valid_reg || s4_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign req_stall = s1_valid_reg && !s2_free;
    assign req_acc   = req_valid && !req_stall;

    // Phase memory. The read is issued with each accepted item; the write happens
    // when the item leaves stage 1.
    stg_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (PHASE_DEPTH)
    ) u_phase_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (PHASE_ADDR),
        .wr_data (phase_next),
        .rd_en   (req_acc),
        .rd_addr (PHASE_ADDR),
        .rd_data (ram_rd_data)
    );

    // If the read went out at the same edge as the previous item's write, the RAM
    // returned stale data and the bypass register holds the right value. Before the
    // first write the entry holds nothing and reads as zero.
    always_comb
    begin
        priority if (fwd_hit_reg)
        begin
            phase_old = fwd_phase_reg;
        end
        else if (phase_valid_reg)
        begin
            phase_old = ram_rd_data;
        end
        else
        begin
            phase_old = '0;
        end
    end

    assign phase_next = (s1_first_reg ? '0 : phase_old) + PHASE_BITS'(phase_step_reg);

    // Table address: the quadrant folds the quarter wave; odd quadrants run backward.
    assign idx      = phase_next[PHASE_BITS-1 -: IDX_BITS];
    assign quad     = idx[IDX_BITS-1 -: 2];
    assign k_ext    = QTAB_AW'(idx[TABLE_BITS-1:0]);
    assign tab_addr = quad[0] ? (QTAB_AW'(1 << TABLE_BITS) - k_ext) : k_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            phase_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                s1_valid_reg <= req_valid;
            end
            if (req_acc)
            begin
                fwd_hit_reg <= s1_adv;
            end
            if (s1_adv)
            begin
                phase_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_first_reg  <= req.first_frame;
            s1_last_reg   <= req.last_frame;
            fwd_phase_reg <= phase_next;
        end
    end

    // Stage 2: table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            q_reg       <= QTAB[tab_addr];
            s2_neg_reg  <= quad[1];
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: scale by amplitude.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            prod_reg    <= PROD_W'(q_reg) * PROD_W'(amplitude_reg);
            s3_neg_reg  <= s2_neg_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stage 4: the magnitude is truncated, then negated, so rounding is toward zero.
    assign mag      = prod_reg[PROD_W-1 -: AMP_W];
    assign smp_next = s3_neg_reg ? (SAMPLE_W'(0) - SAMPLE_W'(mag)) : SAMPLE_W'(mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rsp_acc)
            begin
                cnt_reg <= ch_last ? '0 : (cnt_reg + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s4_free)
        begin
            smp_reg     <= smp_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    assign rsp_valid      = s4_valid_reg;
    assign rsp.sample     = smp_reg;
    assign rsp.channel    = cnt_reg[2:0] & 3'h7;
    assign rsp.frame_end  = ch_last;
    assign rsp.buffer_end = ch_last && s4_last_reg;

`ifndef SYNTH
    // Once the bypass is taken, the phase entry has been written at least once.
    a_fwd_implies_written: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> phase_valid_reg)
        else $error("bypass used before the phase entry was written");

    // The channel counter stays below the effective channel count.
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (CHANS_W'(cnt_reg) < chans))
        else $error("channel counter out of range");

    // A taken result that is not the frame's last is followed by the next channel.
    a_next_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_acc && !rsp.frame_end) |=>
            (rsp_valid && (rsp.channel == 3'($past(rsp.channel) + 3'd1))))
        else $error("frame cut short or channel skipped");

    // The phase is written only as an item leaves stage 1, never twice for one item.
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !req_acc) |=> !s1_valid_reg)
        else $error("stage 1 kept an item after its phase write");
`endif

endmodule
